// File: hdl/tds_pkg.sv
`default_nettype none
package tds_pkg;

    localparam int DEF_MAX_TASKS = 64;

    localparam int ID_W    = 8;
    localparam int ARR_W   = 16;
    localparam int EXE_W   = 16;
    localparam int PRIO_W  = 8;
    localparam int TIME_W  = 23;
    localparam int QUANT_W = 16;
    localparam int ACT_W   = 2;
    localparam int MODE_W  = 2;
    localparam int CIDX_W  = 2;

    localparam logic [ACT_W-1:0] ACT_LOAD     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DISPATCH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SJF  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RR   = 2'd3;

    localparam logic [CIDX_W-1:0] REG_POLICY  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_QUANTUM = 2'd1;

    localparam logic [1:0] ST_WAIT   = 2'd1;
    localparam logic [1:0] ST_QUEUED = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ARR_W-1:0]  arrival;
        logic [EXE_W-1:0]  execution;
        logic [PRIO_W-1:0] priority_lvl;
        logic [EXE_W-1:0]  remaining;
        logic [1:0]        status;
    } entry_t;

    typedef struct packed {
        logic [ID_W-1:0]   task_id;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic              task_finished;
        logic              schedule_done;
    } result_t;

    typedef struct packed {
        logic [MODE_W-1:0]  policy_mode;
        logic [QUANT_W-1:0] time_quantum;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_ADMIT_PUSH,
        S_PURGE,
        S_PURGE_RING,
        S_PURGE_ENT,
        S_RR_FIN,
        S_NP_RUN,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        SK_NP,
        SK_ADMIT,
        SK_EARLY
    } scan_kind_t;

    typedef enum logic [1:0] {
        PH_PRE,
        PH_JUMP,
        PH_POST
    } phase_t;

endpackage
`default_nettype wire

// File: hdl/tds_ifs.sv
`default_nettype none
interface tds_in_if import tds_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [ID_W-1:0]    task_id;
    logic [ARR_W-1:0]   task_arrival;
    logic [EXE_W-1:0]   task_execution;
    logic [PRIO_W-1:0]  task_priority;

    modport source (output valid, action, task_id, task_arrival, task_execution,
                    task_priority, input ready);
    modport sink (input valid, action, task_id, task_arrival, task_execution,
                  task_priority, output ready);
endinterface

interface tds_out_if import tds_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    out_task_id;
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  end_time;
    logic               task_finished;
    logic               schedule_done;

    modport source (output valid, out_task_id, start_time, end_time, task_finished,
                    schedule_done, input ready);
    modport sink (input valid, out_task_id, start_time, end_time, task_finished,
                  schedule_done, output ready);
endinterface

interface tds_cfg_if import tds_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CIDX_W-1:0]  index;
    logic [QUANT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/tds_ram.sv
`default_nettype none
module tds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: hdl/tds_ctrl.sv
`default_nettype none
module tds_ctrl import tds_pkg::*; #(
    parameter int MAX_TASKS = DEF_MAX_TASKS
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tds_in_if.sink       task_in,
    input  wire cfg_t    cfg,
    input  wire logic    out_free,
    output logic         res_valid,
    output result_t      res
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int EW = $bits(entry_t);
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_TASKS);
    localparam logic [IW-1:0] LAST_I = IW'(MAX_TASKS - 1);

    state_t            state_reg, state_next;
    scan_kind_t        kind_reg, kind_next;
    phase_t            phase_reg, phase_next;
    logic              pass2_reg, pass2_next;
    logic [CW-1:0]     loaded_reg, loaded_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [IW-1:0]     head_reg, head_next;
    logic [IW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [CW-1:0]     scan_idx_reg, scan_idx_next;
    logic              dv_reg, dv_next;
    logic [IW-1:0]     didx_reg, didx_next;
    logic              best_vld_reg, best_vld_next;
    logic [IW-1:0]     best_idx_reg, best_idx_next;
    logic              any_reg, any_next;
    logic [IW-1:0]     slot_reg, slot_next;
    entry_t            best_word_reg, best_word_next;
    entry_t            rr_word_reg, rr_word_next;
    logic [ARR_W-1:0]  first_reg, first_next;
    logic [TIME_W-1:0] start_reg, start_next;
    result_t           res_reg, res_next;

    logic              ent_we;
    logic [IW-1:0]     ent_waddr, ent_raddr;
    entry_t            ent_wdata;
    logic [EW-1:0]     ent_rdata;
    entry_t            ent_q;
    logic              ring_we;
    logic [IW-1:0]     ring_waddr, ring_wdata, ring_rdata;

    logic              in_fire, scan_issue, scan_fin, ring_full, stale;
    logic              arrived, unf, cand, ahead, take, first_upd, rst_scan;
    logic [EXE_W-1:0]  key_new, key_best, quantum, run;
    result_t           done_res;

    tds_ram #(.WIDTH(EW), .DEPTH(MAX_TASKS)) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    tds_ram #(.WIDTH(IW), .DEPTH(MAX_TASKS)) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (head_reg),
        .rdata (ring_rdata)
    );

    assign ent_q          = entry_t'(ent_rdata);
    assign task_in.ready  = (state_reg == S_IDLE);
    assign in_fire        = task_in.valid && (state_reg == S_IDLE);
    assign scan_issue     = (scan_idx_reg < loaded_reg);
    assign scan_fin       = (state_reg == S_SCAN) && !scan_issue && !dv_reg;
    assign ring_full      = (fill_reg == MAX_C);
    assign stale          = (ent_q.status != ST_QUEUED);
    assign ent_raddr      = (state_reg == S_PURGE_RING) ? ring_rdata : scan_idx_reg[IW-1:0];
    assign res_valid      = (state_reg == S_EMIT);
    assign res            = res_reg;
    assign quantum        = (cfg.time_quantum == '0) ? EXE_W'(1) : cfg.time_quantum;
    assign run            = (quantum > ent_q.remaining) ? ent_q.remaining : quantum;

    always_comb
    begin
        done_res = '0;
        done_res.schedule_done = 1'b1;
    end

    // candidate evaluation on the entry that just came out of the table
    always_comb
    begin
        arrived = (TIME_W'(ent_q.arrival) <= time_reg);
        unf     = (ent_q.status == ST_WAIT) || (ent_q.status == ST_QUEUED);
        unique case (kind_reg)
            SK_NP:    cand = unf && arrived;
            SK_ADMIT: cand = (ent_q.status == ST_WAIT) && arrived;
            default:  cand = (ent_q.status == ST_WAIT);
        endcase
        key_new  = '0;
        key_best = '0;
        if (kind_reg == SK_NP)
        begin
            unique case (cfg.policy_mode)
                MODE_SJF:
                begin
                    key_new  = ent_q.execution;
                    key_best = best_word_reg.execution;
                end
                MODE_PRIO:
                begin
                    key_new  = EXE_W'(ent_q.priority_lvl);
                    key_best = EXE_W'(best_word_reg.priority_lvl);
                end
                MODE_FCFS, MODE_RR:
                begin
                    key_new  = '0;
                    key_best = '0;
                end
            endcase
        end
        ahead = (key_new != key_best) ? (key_new < key_best)
                                      : (ent_q.arrival < best_word_reg.arrival);
        take      = dv_reg && cand && (!best_vld_reg || ahead);
        first_upd = dv_reg && (kind_reg == SK_NP) && unf
                    && (!any_reg || (ent_q.arrival < first_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (task_in.action == ACT_DISPATCH))
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_fin)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                unique case (kind_reg)
                    SK_NP:
                    begin
                        if (any_reg && best_vld_reg)
                            state_next = S_NP_RUN;
                        else if (any_reg && !pass2_reg)
                            state_next = S_SCAN;
                        else
                            state_next = S_EMIT;
                    end
                    SK_ADMIT:
                    begin
                        if (best_vld_reg)
                            state_next = S_ADMIT_PUSH;
                        else if (phase_reg == PH_POST)
                            state_next = S_RR_FIN;
                        else
                            state_next = S_PURGE;
                    end
                    default:
                    begin
                        state_next = best_vld_reg ? S_SCAN : S_EMIT;
                    end
                endcase
            end
            S_ADMIT_PUSH: state_next = S_SCAN;
            S_PURGE:
            begin
                if (fill_reg != '0)
                    state_next = S_PURGE_RING;
                else if (phase_reg == PH_PRE)
                    state_next = S_SCAN;
                else
                    state_next = S_EMIT;
            end
            S_PURGE_RING: state_next = S_PURGE_ENT;
            S_PURGE_ENT:  state_next = stale ? S_PURGE : S_SCAN;
            S_RR_FIN:     state_next = S_EMIT;
            S_NP_RUN:     state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        kind_next      = kind_reg;
        phase_next     = phase_reg;
        pass2_next     = pass2_reg;
        loaded_next    = loaded_reg;
        time_next      = time_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        scan_idx_next  = scan_idx_reg;
        dv_next        = dv_reg;
        didx_next      = didx_reg;
        best_vld_next  = best_vld_reg;
        best_idx_next  = best_idx_reg;
        any_next       = any_reg;
        slot_next      = slot_reg;
        best_word_next = best_word_reg;
        rr_word_next   = rr_word_reg;
        first_next     = first_reg;
        start_next     = start_reg;
        res_next       = res_reg;
        ent_we         = 1'b0;
        ent_waddr      = best_idx_reg;
        ent_wdata      = best_word_reg;
        ring_we        = 1'b0;
        ring_waddr     = tail_reg;
        ring_wdata     = best_idx_reg;
        rst_scan       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (task_in.action)
                        ACT_LOAD:
                        begin
                            if (loaded_reg < MAX_C)
                            begin
                                ent_we                 = 1'b1;
                                ent_waddr              = loaded_reg[IW-1:0];
                                ent_wdata.id           = task_in.task_id;
                                ent_wdata.arrival      = task_in.task_arrival;
                                ent_wdata.execution    = task_in.task_execution;
                                ent_wdata.priority_lvl = task_in.task_priority;
                                ent_wdata.remaining    = task_in.task_execution;
                                ent_wdata.status       = ST_WAIT;
                                loaded_next            = loaded_reg + CW'(1);
                            end
                        end
                        ACT_DISPATCH:
                        begin
                            pass2_next = 1'b0;
                            phase_next = PH_PRE;
                            kind_next  = (cfg.policy_mode == MODE_RR) ? SK_ADMIT : SK_NP;
                            rst_scan   = 1'b1;
                        end
                        ACT_CLEAR:
                        begin
                            loaded_next = '0;
                            time_next   = '0;
                            head_next   = '0;
                            tail_next   = '0;
                            fill_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_issue)
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                dv_next   = scan_issue;
                didx_next = scan_idx_reg[IW-1:0];
                if (take)
                begin
                    best_vld_next  = 1'b1;
                    best_idx_next  = didx_reg;
                    best_word_next = ent_q;
                end
                if (first_upd)
                begin
                    first_next = ent_q.arrival;
                    any_next   = 1'b1;
                end
            end
            S_SCAN_END:
            begin
                unique case (kind_reg)
                    SK_NP:
                    begin
                        if (!any_reg || (!best_vld_reg && pass2_reg))
                        begin
                            res_next = done_res;
                        end
                        else if (!best_vld_reg)
                        begin
                            time_next  = TIME_W'(first_reg);
                            pass2_next = 1'b1;
                            rst_scan   = 1'b1;
                        end
                    end
                    SK_ADMIT:
                    begin
                    end
                    default:
                    begin
                        if (best_vld_reg)
                        begin
                            if (time_reg < TIME_W'(best_word_reg.arrival))
                            begin
                                time_next = TIME_W'(best_word_reg.arrival);
                            end
                            kind_next  = SK_ADMIT;
                            phase_next = PH_JUMP;
                            rst_scan   = 1'b1;
                        end
                        else
                        begin
                            res_next = done_res;
                        end
                    end
                endcase
            end
            S_ADMIT_PUSH:
            begin
                ent_we           = 1'b1;
                ent_wdata.status = ST_QUEUED;
                if (!ring_full)
                begin
                    ring_we   = 1'b1;
                    tail_next = (tail_reg == LAST_I) ? '0 : tail_reg + IW'(1);
                    fill_next = fill_reg + CW'(1);
                end
                rst_scan = 1'b1;
            end
            S_PURGE:
            begin
                if (fill_reg == '0)
                begin
                    if (phase_reg == PH_PRE)
                    begin
                        kind_next = SK_EARLY;
                        rst_scan  = 1'b1;
                    end
                    else
                    begin
                        res_next = done_res;
                    end
                end
            end
            S_PURGE_RING:
            begin
                slot_next = ring_rdata;
            end
            S_PURGE_ENT:
            begin
                head_next = (head_reg == LAST_I) ? '0 : head_reg + IW'(1);
                fill_next = fill_reg - CW'(1);
                if (!stale)
                begin
                    start_next             = time_reg;
                    time_next              = time_reg + TIME_W'(run);
                    rr_word_next           = ent_q;
                    rr_word_next.remaining = ent_q.remaining - run;
                    kind_next              = SK_ADMIT;
                    phase_next             = PH_POST;
                    rst_scan               = 1'b1;
                end
            end
            S_RR_FIN:
            begin
                ent_we    = 1'b1;
                ent_waddr = slot_reg;
                ent_wdata = rr_word_reg;
                if (rr_word_reg.remaining == '0)
                begin
                    ent_wdata.status = ST_DONE;
                end
                else if (!ring_full)
                begin
                    ring_we    = 1'b1;
                    ring_wdata = slot_reg;
                    tail_next  = (tail_reg == LAST_I) ? '0 : tail_reg + IW'(1);
                    fill_next  = fill_reg + CW'(1);
                end
                res_next.task_id       = rr_word_reg.id;
                res_next.start_time    = start_reg;
                res_next.end_time      = time_reg;
                res_next.task_finished = (rr_word_reg.remaining == '0);
                res_next.schedule_done = 1'b0;
            end
            S_NP_RUN:
            begin
                ent_we              = 1'b1;
                ent_wdata.remaining = '0;
                ent_wdata.status    = ST_DONE;
                time_next           = time_reg + TIME_W'(best_word_reg.remaining);
                res_next.task_id       = best_word_reg.id;
                res_next.start_time    = time_reg;
                res_next.end_time      = time_reg + TIME_W'(best_word_reg.remaining);
                res_next.task_finished = 1'b1;
                res_next.schedule_done = 1'b0;
            end
            S_EMIT:
            begin
            end
            default:
            begin
            end
        endcase

        if (rst_scan)
        begin
            scan_idx_next = '0;
            dv_next       = 1'b0;
            best_vld_next = 1'b0;
            any_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            kind_reg     <= SK_NP;
            phase_reg    <= PH_PRE;
            pass2_reg    <= 1'b0;
            loaded_reg   <= '0;
            time_reg     <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            scan_idx_reg <= '0;
            dv_reg       <= 1'b0;
            best_vld_reg <= 1'b0;
            any_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            phase_reg    <= phase_next;
            pass2_reg    <= pass2_next;
            loaded_reg   <= loaded_next;
            time_reg     <= time_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fill_reg     <= fill_next;
            scan_idx_reg <= scan_idx_next;
            dv_reg       <= dv_next;
            best_vld_reg <= best_vld_next;
            any_reg      <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        didx_reg      <= didx_next;
        best_idx_reg  <= best_idx_next;
        slot_reg      <= slot_next;
        best_word_reg <= best_word_next;
        rr_word_reg   <= rr_word_next;
        first_reg     <= first_next;
        start_reg     <= start_next;
        res_reg       <= res_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= MAX_C)
        else $error("ready ring fill exceeds capacity");

    a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= MAX_C)
        else $error("loaded count exceeds table depth");

    a_emit_release: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=> state_reg == S_IDLE)
        else $error("result handoff did not return to idle");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PURGE_RING) |-> fill_reg != '0)
        else $error("ring read while empty");

endmodule
`default_nettype wire

// File: hdl/task_dispatch_scheduler.sv
// Task table and dispatcher.
// task_in carries one transaction per action: load a task into the next free
// slot (ignored when the table is full), dispatch the next schedule entry, or
// clear the table and time. Only a dispatch yields a transaction on sched_out.
// cfg writes policy_mode (index 0) and time_quantum (index 1); write it only
// while no dispatch is in progress.
// A dispatch scans the task table in its memory, one slot a cycle, and each
// scan closes with a wrap-up in S_SCAN_END. A non-preemptive dispatch runs
// one scan, and a second one when time must jump ahead. Round robin runs one
// scan per task admitted to the ready ring plus one closing scan before and
// one after the run, and steps through S_PURGE, S_PURGE_RING and S_PURGE_ENT
// for each ring entry popped.
// The result sits in an output register; task_in is held off while a finished
// result cannot enter it, so a stalled receiver stalls the block.
// Reset empties the table, zeroes time, empties the ring and sets FCFS mode
// with a quantum of 1. The memories need no clearing pass.
`default_nettype none
module task_dispatch_scheduler import tds_pkg::*; #(
    parameter int MAX_TASKS = DEF_MAX_TASKS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tds_in_if.sink    task_in,
    tds_out_if.source sched_out,
    tds_cfg_if.sink   cfg
);

    cfg_t    cfg_reg, cfg_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    out_free, res_valid;
    result_t res;

    assign cfg.ready = 1'b1;
    assign out_free  = !out_valid_reg || sched_out.ready;

    tds_ctrl #(.MAX_TASKS(MAX_TASKS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .task_in   (task_in),
        .cfg       (cfg_reg),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_POLICY:  cfg_next.policy_mode  = cfg.data[MODE_W-1:0];
                REG_QUANTUM: cfg_next.time_quantum = cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && out_free)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (sched_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.policy_mode  <= MODE_FCFS;
            cfg_reg.time_quantum <= QUANT_W'(1);
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign sched_out.valid         = out_valid_reg;
    assign sched_out.out_task_id   = out_reg.task_id;
    assign sched_out.start_time    = out_reg.start_time;
    assign sched_out.end_time      = out_reg.end_time;
    assign sched_out.task_finished = out_reg.task_finished;
    assign sched_out.schedule_done = out_reg.schedule_done;

endmodule
`default_nettype wire

// File: tb/tds_test_ifs.sv
`timescale 1ns / 1ps

// File: tb/task_dispatch_scheduler_test.sv
`timescale 1ns / 1ps
module task_dispatch_scheduler_test;
    import tds_pkg::*;

    localparam int SLOTS = 64;
    localparam logic [TIME_W-1:0] TMASK = {TIME_W{1'b1}};

    typedef struct {
        logic [ACT_W-1:0]  act;
        logic [ID_W-1:0]   id;
        logic [ARR_W-1:0]  arr;
        logic [EXE_W-1:0]  exe;
        logic [PRIO_W-1:0] prio;
        bit                typed;
        result_t           res;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tds_in_if  task_in ();
    tds_out_if sched_out ();
    tds_cfg_if cfg ();

    task_dispatch_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .task_in   (task_in),
        .sched_out (sched_out),
        .cfg       (cfg)
    );

    always #2 clk = ~clk;

    // scheduler mirror
    logic [MODE_W-1:0]  m_mode;
    logic [QUANT_W-1:0] m_quant;
    logic [ID_W-1:0]    t_id[SLOTS];
    logic [ARR_W-1:0]   t_arr[SLOTS];
    logic [EXE_W-1:0]   t_exe[SLOTS];
    logic [PRIO_W-1:0]  t_prio[SLOTS];
    logic [EXE_W-1:0]   t_rem[SLOTS];
    logic [1:0]         t_st[SLOTS];
    int                 n_loaded;
    logic [TIME_W-1:0]  now;
    int                 ring[SLOTS];
    int                 r_head, r_tail, r_fill;

    result_t pending_results[$];
    int      n_errors = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    bit      hold_recv = 1'b0;
    bit      hold_used = 1'b0;
    int      hold_cycles = 0;

    task automatic wipe_table();
        for (int i = 0; i < SLOTS; i++) t_st[i] = 2'd0;
        n_loaded = 0;
        now = '0;
        r_head = 0;
        r_tail = 0;
        r_fill = 0;
    endtask

    function automatic int earliest_waiting(bit only_arrived);
        int best;
        best = -1;
        for (int i = 0; i < n_loaded; i++) begin
            if (t_st[i] != ST_WAIT) continue;
            if (only_arrived && TIME_W'(t_arr[i]) > now) continue;
            if (best < 0 || t_arr[i] < t_arr[best]) best = i;
        end
        return best;
    endfunction

    task automatic admit_arrived();
        int s;
        s = earliest_waiting(1'b1);
        while (s >= 0) begin
            t_st[s] = ST_QUEUED;
            if (r_fill < SLOTS) begin
                ring[r_tail] = s;
                r_tail = (r_tail + 1) % SLOTS;
                r_fill++;
            end
            s = earliest_waiting(1'b1);
        end
    endtask

    task automatic purge_stale();
        while (r_fill > 0 && t_st[ring[r_head]] != ST_QUEUED) begin
            r_head = (r_head + 1) % SLOTS;
            r_fill--;
        end
    endtask

    function automatic bit ranks_ahead(int a, int b);
        int ka, kb;
        ka = 0;
        kb = 0;
        if (m_mode == MODE_SJF) begin
            ka = t_exe[a];
            kb = t_exe[b];
        end else if (m_mode == MODE_PRIO) begin
            ka = t_prio[a];
            kb = t_prio[b];
        end
        if (ka != kb) return ka < kb;
        return t_arr[a] < t_arr[b];
    endfunction

    function automatic int pick_next();
        int best;
        best = -1;
        for (int i = 0; i < n_loaded; i++) begin
            if (t_st[i] != ST_WAIT && t_st[i] != ST_QUEUED) continue;
            if (TIME_W'(t_arr[i]) > now) continue;
            if (best < 0 || ranks_ahead(i, best)) best = i;
        end
        return best;
    endfunction

    task automatic predict_dispatch(output result_t r);
        int s, slot;
        bit found;
        logic [ARR_W-1:0] first;
        logic [EXE_W-1:0] run;
        logic [TIME_W-1:0] start;
        r = '0;
        found = 1'b0;
        first = '0;
        slot = -1;
        if (m_mode == MODE_RR) begin
            admit_arrived();
            purge_stale();
            if (r_fill == 0) begin
                s = earliest_waiting(1'b0);
                if (s < 0) begin
                    r.schedule_done = 1'b1;
                    return;
                end
                if (now < TIME_W'(t_arr[s])) now = TIME_W'(t_arr[s]);
                admit_arrived();
                purge_stale();
                if (r_fill == 0) begin
                    r.schedule_done = 1'b1;
                    return;
                end
            end
            slot = ring[r_head];
            r_head = (r_head + 1) % SLOTS;
            r_fill--;
            run = (m_quant == 0) ? 16'd1 : m_quant;
            if (run > t_rem[slot]) run = t_rem[slot];
            start = now;
            now = (now + TIME_W'(run)) & TMASK;
            t_rem[slot] = t_rem[slot] - run;
            admit_arrived();
            if (t_rem[slot] > 0) begin
                if (r_fill < SLOTS) begin
                    ring[r_tail] = slot;
                    r_tail = (r_tail + 1) % SLOTS;
                    r_fill++;
                end
            end else begin
                t_st[slot] = ST_DONE;
            end
        end else begin
            for (int i = 0; i < n_loaded; i++) begin
                if (t_st[i] != ST_WAIT && t_st[i] != ST_QUEUED) continue;
                if (!found || t_arr[i] < first) first = t_arr[i];
                found = 1'b1;
            end
            if (!found) begin
                r.schedule_done = 1'b1;
                return;
            end
            s = pick_next();
            if (s < 0) begin
                now = TIME_W'(first);
                s = pick_next();
                if (s < 0) begin
                    r.schedule_done = 1'b1;
                    return;
                end
            end
            slot = s;
            start = now;
            now = (now + TIME_W'(t_rem[slot])) & TMASK;
            t_rem[slot] = '0;
            t_st[slot] = ST_DONE;
        end
        r.task_id = t_id[slot];
        r.start_time = start;
        r.end_time = now;
        r.task_finished = (t_rem[slot] == 0);
        r.schedule_done = 1'b0;
    endtask

    // returns 1 when a result is expected
    task automatic predict_item(input row_t it, output bit has, output result_t r);
        has = 1'b0;
        r = '0;
        if (it.act == ACT_LOAD) begin
            if (n_loaded < SLOTS) begin
                t_id[n_loaded] = it.id;
                t_arr[n_loaded] = it.arr;
                t_exe[n_loaded] = it.exe;
                t_prio[n_loaded] = it.prio;
                t_rem[n_loaded] = it.exe;
                t_st[n_loaded] = ST_WAIT;
                n_loaded++;
            end
        end else if (it.act == ACT_DISPATCH) begin
            predict_dispatch(r);
            has = 1'b1;
        end else if (it.act == ACT_CLEAR) begin
            wipe_table();
        end
    endtask

    task automatic send_item(input row_t it);
        bit has;
        result_t r;
        cfg.valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            task_in.valid <= 1'b0;
            @(posedge clk);
        end
        task_in.valid <= 1'b1;
        task_in.action <= it.act;
        task_in.task_id <= it.id;
        task_in.task_arrival <= it.arr;
        task_in.task_execution <= it.exe;
        task_in.task_priority <= it.prio;
        @(posedge clk);
        while (!task_in.ready) @(posedge clk);
        predict_item(it, has, r);
        if (has) begin
            if (it.typed && r != it.res) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("typed row differs from prediction: row %h pred %h", it.res, r);
            end
            pending_results.insert(pending_results.size(), r);
        end
    endtask

    task automatic drain();
        task_in.valid <= 1'b0;
        cfg.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [QUANT_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        if (idx == REG_POLICY) m_mode = MODE_W'(val);
        else if (idx == REG_QUANTUM) m_quant = val;
    endtask

    function automatic row_t mk(logic [ACT_W-1:0] a, int id, int arr, int exe, int pr);
        row_t it;
        it.act = a;
        it.id = ID_W'(id);
        it.arr = ARR_W'(arr);
        it.exe = EXE_W'(exe);
        it.prio = PRIO_W'(pr);
        it.typed = 1'b0;
        it.res = '0;
        return it;
    endfunction

    function automatic row_t mk_res(int id, int st, int en, bit fin, bit done);
        row_t it;
        it = mk(ACT_DISPATCH, 0, 0, 0, 0);
        it.typed = 1'b1;
        it.res.task_id = ID_W'(id);
        it.res.start_time = TIME_W'(st);
        it.res.end_time = TIME_W'(en);
        it.res.task_finished = fin;
        it.res.schedule_done = done;
        return it;
    endfunction

    function automatic row_t rand_load(int amax, int emax);
        return mk(ACT_LOAD, $urandom_range(255), $urandom_range(amax),
                  $urandom_range(emax), $urandom_range(255));
    endfunction

    // receiver
    always @(posedge clk) begin
        result_t exp_r;
        result_t got;
        if (!rst_n) begin
            sched_out.ready <= 1'b0;
        end else begin
            if (sched_out.valid && sched_out.ready) begin
                got.task_id = sched_out.out_task_id;
                got.start_time = sched_out.start_time;
                got.end_time = sched_out.end_time;
                got.task_finished = sched_out.task_finished;
                got.schedule_done = sched_out.schedule_done;
                if (pending_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) $display("unexpected schedule entry %h", got);
                end else begin
                    exp_r = pending_results.pop_front();
                    if (got != exp_r) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("entry mismatch: expected id %0d start %0d end %0d fin %0b done %0b, got id %0d start %0d end %0d fin %0b done %0b",
                                     exp_r.task_id, exp_r.start_time, exp_r.end_time,
                                     exp_r.task_finished, exp_r.schedule_done,
                                     got.task_id, got.start_time, got.end_time,
                                     got.task_finished, got.schedule_done);
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                sched_out.ready <= 1'b0;
            end else if (hold_recv && !hold_used) begin
                hold_cycles <= 3000;
                hold_used <= 1'b1;
                sched_out.ready <= 1'b0;
            end else begin
                sched_out.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        #200_000_000;
        $display("task_dispatch_scheduler_test: done, errors");
        $finish;
    end

    initial begin
        row_t rows[$];
        row_t it;
        int kind, sz, phase;
        task_in.valid = 1'b0;
        task_in.action = ACT_LOAD;
        task_in.task_id = '0;
        task_in.task_arrival = '0;
        task_in.task_execution = '0;
        task_in.task_priority = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_POLICY;
        cfg.data = '0;
        m_mode = MODE_FCFS;
        m_quant = 16'd1;
        wipe_table();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        rows.insert(rows.size(), mk_res(0, 0, 0, 0, 1));
        rows.insert(rows.size(), mk(ACT_LOAD, 255, 65535, 65535, 255));
        rows.insert(rows.size(), mk(ACT_LOAD, 0, 0, 0, 0));
        rows.insert(rows.size(), mk_res(0, 0, 0, 1, 0));
        rows.insert(rows.size(), mk_res(255, 65535, 131070, 1, 0));
        rows.insert(rows.size(), mk_res(0, 0, 0, 0, 1));
        rows.insert(rows.size(), mk(2'd3, 7, 7, 7, 7));
        rows.insert(rows.size(), mk(ACT_CLEAR, 0, 0, 0, 0));
        rows.insert(rows.size(), mk(ACT_LOAD, 1, 5, 9, 3));
        rows.insert(rows.size(), mk(ACT_LOAD, 2, 5, 2, 1));
        rows.insert(rows.size(), mk(ACT_LOAD, 3, 0, 4, 9));
        rows.insert(rows.size(), mk(ACT_LOAD, 4, 5, 2, 0));
        rows.insert(rows.size(), mk_res(3, 0, 4, 1, 0));
        rows.insert(rows.size(), mk(ACT_DISPATCH, 0, 0, 0, 0));
        rows.insert(rows.size(), mk(ACT_LOAD, 5, 1, 1, 1));
        rows.insert(rows.size(), mk(ACT_DISPATCH, 0, 0, 0, 0));
        rows.insert(rows.size(), mk(ACT_DISPATCH, 0, 0, 0, 0));
        rows.insert(rows.size(), mk(ACT_DISPATCH, 0, 0, 0, 0));
        rows.insert(rows.size(), mk(ACT_DISPATCH, 0, 0, 0, 0));
        foreach (rows[i]) send_item(rows[i]);
        drain();

        for (int md = 1; md < 4; md++) begin
            write_reg(REG_POLICY, QUANT_W'(md));
            write_reg(REG_QUANTUM, (md == 3) ? 16'd0 : 16'd3);
            send_item(mk(ACT_CLEAR, 0, 0, 0, 0));
            for (int k = 0; k < 6; k++) send_item(rand_load(10, 8));
            for (int k = 0; k < 8; k++) send_item(mk(ACT_DISPATCH, 0, 0, 0, 0));
            drain();
        end

        // full table, then overflow load
        send_item(mk(ACT_CLEAR, 0, 0, 0, 0));
        for (int k = 0; k < 66; k++) send_item(rand_load(65535, 65535));
        for (int k = 0; k < 3; k++) send_item(mk(ACT_DISPATCH, 0, 0, 0, 0));
        drain();

        // random sessions
        for (int sess = 0; sess < 30; sess++) begin
            phase = sess % 4;
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 13 : 86) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 13 : 86) : 0;
            if (sess == 0) send_idle_pct = 0;
            case (sess % 7)
                0: write_reg(REG_POLICY, QUANT_W'(MODE_FCFS));
                1: write_reg(REG_POLICY, QUANT_W'(MODE_SJF));
                2: write_reg(REG_POLICY, QUANT_W'(MODE_PRIO));
                default: write_reg(REG_POLICY, QUANT_W'(MODE_RR));
            endcase
            case ($urandom_range(3))
                0: write_reg(REG_QUANTUM, 16'hFFFF);
                1: write_reg(REG_QUANTUM, 16'd1);
                default: write_reg(REG_QUANTUM, QUANT_W'($urandom_range(1, 6)));
            endcase
            if (sess == 5) hold_recv = 1'b1;
            send_item(mk(ACT_CLEAR, 0, 0, 0, 0));
            sz = (sess % 10 == 9) ? 64 : $urandom_range(2, 10);
            for (int k = 0; k < sz; k++)
                send_item((sess % 10 == 9) ? rand_load(65535, 65535) : rand_load(20, 6));
            for (int k = 0; k < 26; k++) begin
                kind = $urandom_range(99);
                if (kind < 80) it = mk(ACT_DISPATCH, $urandom_range(255), $urandom_range(65535),
                                       $urandom_range(65535), $urandom_range(255));
                else if (kind < 93) it = rand_load(40, 6);
                else if (kind < 96) it = mk(2'd3, 0, 0, 0, 0);
                else it = mk(ACT_CLEAR, 0, 0, 0, 0);
                send_item(it);
                if (sess == 5 && k == 4) hold_recv = 1'b0;
                if (sess == 6 && k == 10) drain();
            end
            drain();
        end

        drain();
        if (n_errors == 0)
            $display("task_dispatch_scheduler_test: done, clean");
        else
            $display("task_dispatch_scheduler_test: done, errors");
        $finish;
    end
endmodule
